### hdl/sbd_pkg.sv
// sbd_pkg: types and constants shared by the short back-reference decoder
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

package sbd_pkg;

  localparam int unsigned WIN_SIZE  = 32;
  localparam int unsigned WIN_IDX_W = $clog2(WIN_SIZE);
  localparam int unsigned FILL_W    = WIN_IDX_W + 1;
  localparam int unsigned CNT_W     = 3;
  localparam logic [7:0]  ESC_CODE  = 8'hFF;

  typedef struct packed {
    logic [7:0] code_byte;
    logic       chunk_last;
  } in_word_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       run_last;
    logic       chunk_end;
    logic       error_flag;
  } out_word_t;

  typedef enum logic {
    ST_IDLE,
    ST_COPY
  } state_e;

  typedef struct packed {
    logic load;
    logic step;
  } ctrl_cmd_t;

  typedef struct packed {
    logic out_free;
    logic multi;
    logic last_step;
  } ctrl_sts_t;

endpackage

`default_nettype wire

### hdl/short_backreference_decoder.sv
// short_backreference_decoder: top level, controller plus datapath
// depends on sbd_pkg, sbd_ctrl, sbd_datapath
`timescale 1ns / 1ps
`default_nettype none

// Decodes one code byte per input word of a 32-byte-window back-reference code.
// An escape byte, a dropped byte after an error, a literal and an error word
// are each handled as their word is taken; a copy of n bytes (1 to 8) gives
// one decoded byte per cycle while the output is free, since each byte is read
// from the history shift register at the copy distance and pushed back before
// the next one is read. The output word sits in a register, so outside a copy a
// new input word is taken while the last result waits, if that result is taken
// in the same cycle or was taken before. No clearing pass is needed after reset.
module short_backreference_decoder (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  sbd_pkg::in_word_t  in_word_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output sbd_pkg::out_word_t out_word_o
);

  sbd_pkg::ctrl_cmd_t cmd;
  sbd_pkg::ctrl_sts_t sts;

  sbd_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  sbd_datapath u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_word_i   (in_word_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_word_o  (out_word_o),
    .cmd_i       (cmd),
    .sts_o       (sts)
  );

endmodule

`default_nettype wire

### hdl/sbd_ctrl.sv
// sbd_ctrl: controller for the short back-reference decoder
// depends on sbd_pkg
`timescale 1ns / 1ps
`default_nettype none

module sbd_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  sbd_pkg::ctrl_sts_t sts_i,
  output sbd_pkg::ctrl_cmd_t cmd_o
);

  sbd_pkg::state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= sbd_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      sbd_pkg::ST_IDLE: begin
        if (in_valid_i && sts_i.out_free && sts_i.multi) begin
          state_d = sbd_pkg::ST_COPY;
        end
      end
      sbd_pkg::ST_COPY: begin
        if (sts_i.out_free && sts_i.last_step) begin
          state_d = sbd_pkg::ST_IDLE;
        end
      end
      default: state_d = sbd_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    cmd_o      = '0;
    in_stall_o = 1'b1;
    case (state_q)
      sbd_pkg::ST_IDLE: begin
        in_stall_o = !sts_i.out_free;
        cmd_o.load = in_valid_i && sts_i.out_free;
      end
      sbd_pkg::ST_COPY: begin
        cmd_o.step = sts_i.out_free;
      end
      default: begin
        in_stall_o = 1'b1;
      end
    endcase
  end

endmodule

`default_nettype wire

### hdl/sbd_datapath.sv
// sbd_datapath: history shift register, chunk flags, copy counter and output word
// depends on sbd_pkg
`timescale 1ns / 1ps
`default_nettype none

module sbd_datapath (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  sbd_pkg::in_word_t  in_word_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output sbd_pkg::out_word_t out_word_o,
  input  sbd_pkg::ctrl_cmd_t cmd_i,
  output sbd_pkg::ctrl_sts_t sts_o
);

  logic [7:0] hist_q [sbd_pkg::WIN_SIZE];
  logic [sbd_pkg::FILL_W-1:0]    fill_q, fill_d;
  logic                          esc_pend_q, esc_pend_d;
  logic                          err_q, err_d;
  logic [sbd_pkg::WIN_IDX_W-1:0] idx_q, idx_d;
  logic [sbd_pkg::CNT_W-1:0]     rem_q, rem_d;
  logic                          last_q, last_d;
  logic                          out_valid_q, out_valid_d;
  sbd_pkg::out_word_t            out_q, out_d;

  logic                          out_free;
  logic                          is_esc;
  logic                          bad_ref;
  logic [sbd_pkg::WIN_IDX_W-1:0] dist_idx;
  logic [sbd_pkg::CNT_W-1:0]     cnt_m1;
  logic                          push;
  logic [7:0]                    push_byte;
  logic                          end_chunk;
  logic [7:0]                    rd_byte;
  logic [sbd_pkg::WIN_IDX_W-1:0] rd_idx;

  assign out_free = !out_valid_q || !out_stall_i;
  assign is_esc   = (in_word_i.code_byte == sbd_pkg::ESC_CODE);
  assign dist_idx = ~in_word_i.code_byte[7:3];
  assign cnt_m1   = in_word_i.code_byte[2:0];
  assign bad_ref  = ({1'b0, dist_idx} >= fill_q) || ({2'b00, cnt_m1} > dist_idx);
  assign rd_idx   = cmd_i.step ? idx_q : dist_idx;
  assign rd_byte  = hist_q[rd_idx];

  assign sts_o.out_free  = out_free;
  assign sts_o.multi     = !err_q && !esc_pend_q && !is_esc && !bad_ref && (cnt_m1 != '0);
  assign sts_o.last_step = (rem_q == sbd_pkg::CNT_W'(1));

  always_comb begin
    fill_d      = fill_q;
    esc_pend_d  = esc_pend_q;
    err_d       = err_q;
    idx_d       = idx_q;
    rem_d       = rem_q;
    last_d      = last_q;
    out_valid_d = out_valid_q && out_stall_i;
    out_d       = out_q;
    push        = 1'b0;
    push_byte   = rd_byte;
    end_chunk   = 1'b0;

    if (cmd_i.load) begin
      if (err_q) begin
        end_chunk = in_word_i.chunk_last;
      end else if (esc_pend_q) begin
        esc_pend_d  = 1'b0;
        push        = 1'b1;
        push_byte   = in_word_i.code_byte;
        out_valid_d = 1'b1;
        out_d       = '{in_word_i.code_byte, 1'b1, in_word_i.chunk_last, 1'b0};
        end_chunk   = in_word_i.chunk_last;
      end else if (is_esc) begin
        if (in_word_i.chunk_last) begin
          out_valid_d = 1'b1;
          out_d       = '{8'h00, 1'b1, 1'b1, 1'b1};
          end_chunk   = 1'b1;
        end else begin
          esc_pend_d = 1'b1;
        end
      end else if (bad_ref) begin
        out_valid_d = 1'b1;
        out_d       = '{8'h00, 1'b1, 1'b1, 1'b1};
        if (in_word_i.chunk_last) begin
          end_chunk = 1'b1;
        end else begin
          err_d = 1'b1;
        end
      end else begin
        push        = 1'b1;
        out_valid_d = 1'b1;
        out_d       = '{rd_byte, cnt_m1 == '0, (cnt_m1 == '0) && in_word_i.chunk_last, 1'b0};
        end_chunk   = (cnt_m1 == '0) && in_word_i.chunk_last;
        idx_d       = dist_idx;
        rem_d       = cnt_m1;
        last_d      = in_word_i.chunk_last;
      end
    end else if (cmd_i.step) begin
      push        = 1'b1;
      out_valid_d = 1'b1;
      out_d       = '{rd_byte, sts_o.last_step, sts_o.last_step && last_q, 1'b0};
      end_chunk   = sts_o.last_step && last_q;
      rem_d       = rem_q - sbd_pkg::CNT_W'(1);
    end

    if (push && (fill_q < sbd_pkg::FILL_W'(sbd_pkg::WIN_SIZE))) begin
      fill_d = fill_q + sbd_pkg::FILL_W'(1);
    end
    if (end_chunk) begin
      fill_d     = '0;
      esc_pend_d = 1'b0;
      err_d      = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fill_q      <= '0;
      esc_pend_q  <= 1'b0;
      err_q       <= 1'b0;
      rem_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      fill_q      <= fill_d;
      esc_pend_q  <= esc_pend_d;
      err_q       <= err_d;
      rem_q       <= rem_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    idx_q  <= idx_d;
    last_q <= last_d;
    out_q  <= out_d;
    if (push) begin
      hist_q[0] <= push_byte;
      for (int i = 1; i < sbd_pkg::WIN_SIZE; i++) begin
        hist_q[i] <= hist_q[i-1];
      end
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_word_o  = out_q;

endmodule

`default_nettype wire

### hdl/sbd_checker.sv
// sbd_checker: port-level assertions for the short back-reference decoder
// depends on sbd_pkg; bound to short_backreference_decoder
`timescale 1ns / 1ps
`default_nettype none

module sbd_checker (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               in_valid_i,
  input logic               in_stall_o,
  input sbd_pkg::in_word_t  in_word_i,
  input logic               out_valid_o,
  input logic               out_stall_i,
  input sbd_pkg::out_word_t out_word_o
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_word_o))
    else $error("stalled output word changed");

  a_err_word: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_word_o.error_flag |->
      out_word_o.out_byte == 8'h00 && out_word_o.run_last && out_word_o.chunk_end)
    else $error("malformed error word");

  a_end_run: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_word_o.chunk_end |-> out_word_o.run_last)
    else $error("chunk end without run end");

  a_no_take: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |-> in_stall_o)
    else $error("input taken while output blocked");

endmodule

bind short_backreference_decoder sbd_checker u_sbd_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_stall_o  (in_stall_o),
  .in_word_i   (in_word_i),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .out_word_o  (out_word_o)
);

`default_nettype wire
